[design/mer_pkg.sv]
// ----------------------------------------------------------------------------
// mer_pkg
// shared widths, command and status types and operation codes of the
// midpoint ellipse rasterizer
// ----------------------------------------------------------------------------
`default_nettype none

package mer_pkg;

  localparam int COORD_BITS    = 12;
  localparam int RAD_BITS      = COORD_BITS - 1;
  localparam int SQ_BITS       = 2 * RAD_BITS;
  localparam int MOP_BITS      = 2 * COORD_BITS;
  localparam int PROD_BITS     = 2 * MOP_BITS;
  localparam int DEC_BITS      = 48;
  localparam int IN_DATA_BITS  = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((8 * COORD_BITS + 7) / 8) * 8;

  typedef logic [COORD_BITS-1:0] coord_t;

  // input word kinds
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // multiplier operand selection
  typedef logic [3:0] mul_sel_t;
  localparam mul_sel_t MS_NONE      = 4'd0;
  localparam mul_sel_t MS_RXRX      = 4'd1;
  localparam mul_sel_t MS_RYRY      = 4'd2;
  localparam mul_sel_t MS_RXSQ_Y    = 4'd3;
  localparam mul_sel_t MS_RYSQ_X    = 4'd4;
  localparam mul_sel_t MS_ODD_SQ    = 4'd5;
  localparam mul_sel_t MS_RYSQ_P    = 4'd6;
  localparam mul_sel_t MS_YM1_SQ    = 4'd7;
  localparam mul_sel_t MS_RXSQ_P    = 4'd8;
  localparam mul_sel_t MS_RXSQ_RYSQ = 4'd9;

  // what to do with the registered product
  typedef logic [3:0] acc_op_t;
  localparam acc_op_t AC_NONE  = 4'd0;
  localparam acc_op_t AC_RXSQ  = 4'd1;
  localparam acc_op_t AC_RYSQ  = 4'd2;
  localparam acc_op_t AC_PA    = 4'd3;
  localparam acc_op_t AC_DINIT = 4'd4;
  localparam acc_op_t AC_STEP  = 4'd5;
  localparam acc_op_t AC_DSET  = 4'd6;
  localparam acc_op_t AC_DADD4 = 4'd7;
  localparam acc_op_t AC_DSUB4 = 4'd8;

  typedef struct packed {
    logic     load;
    logic     step;
    logic     emit;
    logic     idle_pt;
    mul_sel_t mul_sel;
    acc_op_t  acc;
  } mer_cmd_t;

  typedef struct packed {
    logic cur_y_zero;
    logic ge;
    logic region2;
    logic active;
    logic out_free;
  } mer_status_t;

endpackage

`default_nettype wire

[design/mer_ctrl.sv]
// ----------------------------------------------------------------------------
// mer_ctrl
// sequencer: walks setup, step and region-two entry through the shared
// multiplier and hands the result to the output register
// ----------------------------------------------------------------------------
`default_nettype none

module mer_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_op,
  output logic                     in_ready,
  input  wire mer_pkg::mer_status_t status,
  output mer_pkg::mer_cmd_t        cmd
);
  import mer_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SQX   = 4'd1;
  localparam logic [3:0] ST_SQY   = 4'd2;
  localparam logic [3:0] ST_RXY   = 4'd3;
  localparam logic [3:0] ST_SINIT = 4'd4;
  localparam logic [3:0] ST_MX    = 4'd5;
  localparam logic [3:0] ST_MY    = 4'd6;
  localparam logic [3:0] ST_UPD   = 4'd7;
  localparam logic [3:0] ST_E0    = 4'd8;
  localparam logic [3:0] ST_E1    = 4'd9;
  localparam logic [3:0] ST_E2    = 4'd10;
  localparam logic [3:0] ST_E3    = 4'd11;
  localparam logic [3:0] ST_E4    = 4'd12;
  localparam logic [3:0] ST_E5    = 4'd13;
  localparam logic [3:0] ST_EMIT  = 4'd14;

  logic [3:0] state_r, state_nxt;
  logic       idle_pt_r, idle_pt_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    idle_pt_nxt = idle_pt_r;
    cmd         = '0;
    cmd.mul_sel = MS_NONE;
    cmd.acc     = AC_NONE;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          idle_pt_nxt = 1'b0;
          if (in_op == OP_START) begin
            cmd.load  = 1'b1;
            state_nxt = ST_SQX;
          end else if (status.active) begin
            cmd.step  = 1'b1;
            state_nxt = ST_MX;
          end else begin
            idle_pt_nxt = 1'b1;
            state_nxt   = ST_EMIT;
          end
        end
      end
      ST_SQX: begin
        cmd.mul_sel = MS_RXRX;
        state_nxt   = ST_SQY;
      end
      ST_SQY: begin
        cmd.mul_sel = MS_RYRY;
        cmd.acc     = AC_RXSQ;
        state_nxt   = ST_RXY;
      end
      ST_RXY: begin
        cmd.mul_sel = MS_RXSQ_Y;
        cmd.acc     = AC_RYSQ;
        state_nxt   = ST_SINIT;
      end
      ST_SINIT: begin
        cmd.acc = AC_DINIT;
        if (!status.cur_y_zero && status.ge) begin
          state_nxt = ST_E0;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_MX: begin
        cmd.mul_sel = MS_RYSQ_X;
        state_nxt   = ST_MY;
      end
      ST_MY: begin
        cmd.mul_sel = MS_RXSQ_Y;
        cmd.acc     = AC_PA;
        state_nxt   = ST_UPD;
      end
      ST_UPD: begin
        cmd.acc = AC_STEP;
        // region one turns over once ry^2*x no longer below rx^2*y
        if (!status.region2 && !status.cur_y_zero && status.ge) begin
          state_nxt = ST_E0;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_E0: begin
        cmd.mul_sel = MS_ODD_SQ;
        state_nxt   = ST_E1;
      end
      ST_E1: begin
        cmd.mul_sel = MS_RYSQ_P;
        state_nxt   = ST_E2;
      end
      ST_E2: begin
        cmd.mul_sel = MS_YM1_SQ;
        cmd.acc     = AC_DSET;
        state_nxt   = ST_E3;
      end
      ST_E3: begin
        cmd.mul_sel = MS_RXSQ_P;
        state_nxt   = ST_E4;
      end
      ST_E4: begin
        cmd.mul_sel = MS_RXSQ_RYSQ;
        cmd.acc     = AC_DADD4;
        state_nxt   = ST_E5;
      end
      ST_E5: begin
        cmd.acc   = AC_DSUB4;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit    = 1'b1;
          cmd.idle_pt = idle_pt_r;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      idle_pt_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      idle_pt_r <= idle_pt_nxt;
    end
  end

endmodule

`default_nettype wire

[design/mer_datapath.sv]
// ----------------------------------------------------------------------------
// mer_datapath
// ellipse state, shared multiplier with registered product, decision
// accumulator and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module mer_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire mer_pkg::mer_cmd_t    cmd,
  output mer_pkg::mer_status_t      status,
  input  wire mer_pkg::coord_t      corner_a_x,
  input  wire mer_pkg::coord_t      corner_a_y,
  input  wire mer_pkg::coord_t      corner_b_x,
  input  wire mer_pkg::coord_t      corner_b_y,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output mer_pkg::coord_t           p0_x,
  output mer_pkg::coord_t           p0_y,
  output mer_pkg::coord_t           p1_x,
  output mer_pkg::coord_t           p1_y,
  output mer_pkg::coord_t           p2_x,
  output mer_pkg::coord_t           p2_y,
  output mer_pkg::coord_t           p3_x,
  output mer_pkg::coord_t           p3_y,
  output logic                      last,
  output logic                      idle
);
  import mer_pkg::*;

  coord_t                cx_r, cx_nxt, cy_r, cy_nxt;
  logic [RAD_BITS-1:0]   rx_r, rx_nxt;
  logic [RAD_BITS-1:0]   cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [SQ_BITS-1:0]    rxsq_r, rxsq_nxt, rysq_r, rysq_nxt;
  logic [PROD_BITS-1:0]  prod_r, prod_nxt, pa_r, pa_nxt;
  logic [DEC_BITS-1:0]   dec_r, dec_nxt;
  logic                  moved_r, moved_nxt;
  logic                  region2_r, region2_nxt;
  logic                  active_r, active_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic [MOP_BITS-1:0]   op_a, op_b;
  logic [COORD_BITS-1:0] dx, dy;
  logic [COORD_BITS:0]   sum_x, sum_y;
  logic [DEC_BITS-1:0]   prod_d, pa_d, rxsq_d, rysq_d;
  logic                  step_move;
  logic                  cur_y_zero;
  coord_t                px, nx, py, ny;

  coord_t p0_x_r, p0_y_r, p1_x_r, p1_y_r, p2_x_r, p2_y_r, p3_x_r, p3_y_r;
  logic   last_r, idle_r;

  assign cur_y_zero = (cur_y_r == '0);

  assign status.cur_y_zero = cur_y_zero;
  assign status.ge         = !(pa_r < prod_r);
  assign status.region2    = region2_r;
  assign status.active     = active_r;
  assign status.out_free   = !out_valid_r || out_ready;

  // shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd.mul_sel)
      MS_RXRX: begin
        op_a = MOP_BITS'(rx_r);
        op_b = MOP_BITS'(rx_r);
      end
      MS_RYRY: begin
        op_a = MOP_BITS'(cur_y_r);
        op_b = MOP_BITS'(cur_y_r);
      end
      MS_RXSQ_Y: begin
        op_a = MOP_BITS'(rxsq_r);
        op_b = MOP_BITS'(cur_y_r);
      end
      MS_RYSQ_X: begin
        op_a = MOP_BITS'(rysq_r);
        op_b = MOP_BITS'(cur_x_r);
      end
      MS_ODD_SQ: begin
        op_a = MOP_BITS'({cur_x_r, 1'b1});
        op_b = MOP_BITS'({cur_x_r, 1'b1});
      end
      MS_RYSQ_P: begin
        op_a = MOP_BITS'(rysq_r);
        op_b = prod_r[MOP_BITS-1:0];
      end
      MS_YM1_SQ: begin
        op_a = MOP_BITS'(cur_y_r - 1'b1);
        op_b = MOP_BITS'(cur_y_r - 1'b1);
      end
      MS_RXSQ_P: begin
        op_a = MOP_BITS'(rxsq_r);
        op_b = prod_r[MOP_BITS-1:0];
      end
      MS_RXSQ_RYSQ: begin
        op_a = MOP_BITS'(rxsq_r);
        op_b = MOP_BITS'(rysq_r);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod_nxt = op_a * op_b;

  assign dx    = (corner_a_x > corner_b_x) ? corner_a_x - corner_b_x
                                           : corner_b_x - corner_a_x;
  assign dy    = (corner_a_y > corner_b_y) ? corner_a_y - corner_b_y
                                           : corner_b_y - corner_a_y;
  assign sum_x = {1'b0, corner_a_x} + {1'b0, corner_b_x};
  assign sum_y = {1'b0, corner_a_y} + {1'b0, corner_b_y};

  assign prod_d = DEC_BITS'(prod_r);
  assign pa_d   = DEC_BITS'(pa_r);
  assign rxsq_d = DEC_BITS'(rxsq_r);
  assign rysq_d = DEC_BITS'(rysq_r);

  // region one moves down when the decision is not negative,
  // region two moves across when it is not positive
  assign step_move = region2_r ? (dec_r[DEC_BITS-1] || (dec_r == '0))
                               : !dec_r[DEC_BITS-1];

  always_comb begin
    cx_nxt      = cx_r;
    cy_nxt      = cy_r;
    rx_nxt      = rx_r;
    cur_x_nxt   = cur_x_r;
    cur_y_nxt   = cur_y_r;
    rxsq_nxt    = rxsq_r;
    rysq_nxt    = rysq_r;
    pa_nxt      = pa_r;
    dec_nxt     = dec_r;
    moved_nxt   = moved_r;
    region2_nxt = region2_r;
    active_nxt  = active_r;

    if (cmd.load) begin
      cx_nxt      = sum_x[COORD_BITS:1];
      cy_nxt      = sum_y[COORD_BITS:1];
      rx_nxt      = dx[COORD_BITS-1:1];
      cur_x_nxt   = '0;
      cur_y_nxt   = dy[COORD_BITS-1:1];
      pa_nxt      = '0;
      region2_nxt = 1'b0;
      active_nxt  = 1'b1;
    end

    if (cmd.step) begin
      moved_nxt = step_move;
      if (!region2_r) begin
        cur_x_nxt = cur_x_r + 1'b1;
        if (step_move) begin
          cur_y_nxt = cur_y_r - 1'b1;
        end
      end else begin
        cur_y_nxt = cur_y_r - 1'b1;
        if (step_move) begin
          cur_x_nxt = cur_x_r + 1'b1;
        end
      end
    end

    // pa holds ry^2*x and prod holds rx^2*y during the step update
    case (cmd.acc)
      AC_RXSQ:  rxsq_nxt = prod_r[SQ_BITS-1:0];
      AC_RYSQ:  rysq_nxt = prod_r[SQ_BITS-1:0];
      AC_PA:    pa_nxt   = prod_r;
      AC_DINIT: dec_nxt  = (rysq_d << 2) - (prod_d << 2) + rxsq_d;
      AC_STEP: begin
        if (!region2_r) begin
          dec_nxt = dec_r + (pa_d << 3) + (rysq_d << 2)
                    - (moved_r ? (prod_d << 3) : '0);
        end else begin
          dec_nxt = dec_r + (rxsq_d << 2) - (prod_d << 3)
                    + (moved_r ? (pa_d << 3) : '0);
        end
      end
      AC_DSET:  dec_nxt = prod_d;
      AC_DADD4: dec_nxt = dec_r + (prod_d << 2);
      AC_DSUB4: begin
        dec_nxt     = dec_r - (prod_d << 2);
        region2_nxt = 1'b1;
      end
      default: begin
        dec_nxt = dec_r;
      end
    endcase

    if (cmd.emit && !cmd.idle_pt && cur_y_zero) begin
      active_nxt = 1'b0;
    end
  end

  // mirrored pixels
  assign px = cx_r + COORD_BITS'(cur_x_r);
  assign nx = cx_r - COORD_BITS'(cur_x_r);
  assign py = cy_r + COORD_BITS'(cur_y_r);
  assign ny = cy_r - COORD_BITS'(cur_y_r);

  assign out_valid_nxt = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region2_r   <= 1'b0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      region2_r   <= region2_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    rx_r    <= rx_nxt;
    cur_x_r <= cur_x_nxt;
    cur_y_r <= cur_y_nxt;
    rxsq_r  <= rxsq_nxt;
    rysq_r  <= rysq_nxt;
    prod_r  <= prod_nxt;
    pa_r    <= pa_nxt;
    dec_r   <= dec_nxt;
    moved_r <= moved_nxt;
    if (cmd.emit) begin
      p0_x_r <= cmd.idle_pt ? '0 : px;
      p0_y_r <= cmd.idle_pt ? '0 : py;
      p1_x_r <= cmd.idle_pt ? '0 : px;
      p1_y_r <= cmd.idle_pt ? '0 : ny;
      p2_x_r <= cmd.idle_pt ? '0 : nx;
      p2_y_r <= cmd.idle_pt ? '0 : ny;
      p3_x_r <= cmd.idle_pt ? '0 : nx;
      p3_y_r <= cmd.idle_pt ? '0 : py;
      last_r <= !cmd.idle_pt && cur_y_zero;
      idle_r <= cmd.idle_pt;
    end
  end

  assign out_valid = out_valid_r;
  assign p0_x      = p0_x_r;
  assign p0_y      = p0_y_r;
  assign p1_x      = p1_x_r;
  assign p1_y      = p1_y_r;
  assign p2_x      = p2_x_r;
  assign p2_y      = p2_y_r;
  assign p3_x      = p3_x_r;
  assign p3_y      = p3_y_r;
  assign last      = last_r;
  assign idle      = idle_r;

endmodule

`default_nettype wire

[design/midpoint_ellipse_rasterizer.sv]
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer
// midpoint ellipse rasterizer with stream ports, one result word per input word
// ----------------------------------------------------------------------------
// A start word (in_tuser low) takes two bounding-box corners, sets up the
// ellipse and returns the four points at (0, ry); every step word (in_tuser
// high) advances the midpoint walk by one pixel and returns four mirrored
// pixels, with out_tlast marking the last one and out_tuser set when a step
// arrives with no ellipse running. All products go through one shared
// 24x24 multiplier with a registered product, so a start word, a step word
// and a word that switches the walk into the second region each run through
// a sequence of multiplier states, while a step with no ellipse running goes
// straight to the output. A finished result waits in the output register,
// so the next word is taken while it is still held.
`default_nettype none

module midpoint_ellipse_rasterizer (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // corner_a_x, corner_a_y, corner_b_x, corner_b_y
  input  wire logic [mer_pkg::IN_DATA_BITS-1:0]  in_tdata,
  // operation
  input  wire logic                              in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y
  output logic [mer_pkg::OUT_DATA_BITS-1:0]      out_tdata,
  // idle
  output logic                                   out_tuser,
  output logic                                   out_tlast
);
  import mer_pkg::*;

  mer_cmd_t    cmd;
  mer_status_t status;
  coord_t      p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y;

  mer_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_op    (in_tuser),
    .in_ready (in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mer_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .corner_a_x (in_tdata[COORD_BITS-1:0]),
    .corner_a_y (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .corner_b_x (in_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .corner_b_y (in_tdata[4*COORD_BITS-1:3*COORD_BITS]),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .p0_x       (p0_x),
    .p0_y       (p0_y),
    .p1_x       (p1_x),
    .p1_y       (p1_y),
    .p2_x       (p2_x),
    .p2_y       (p2_y),
    .p3_x       (p3_x),
    .p3_y       (p3_y),
    .last       (out_tlast),
    .idle       (out_tuser)
  );

  assign out_tdata = OUT_DATA_BITS'({p3_y, p3_x, p2_y, p2_x, p1_y, p1_x, p0_y, p0_x});

endmodule

`default_nettype wire
